// ===== hdl/ebfe_pkg.sv =====
// ----------------------------------------------------------------------------
// ebfe_pkg: shared constants and types for the escaped binary frame encoder
// Byte codes of the line framing, CRC-32 constants and the emit step codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ebfe_pkg;

   localparam int BYTE_W = 8;
   localparam int CRC_W  = 32;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CRC_W-1:0]  crc_type;

   // line framing bytes
   localparam byte_type PAD_BYTE  = 8'h2A;
   localparam byte_type ESC_BYTE  = 8'h18;
   localparam byte_type BIN_BYTE  = 8'h41;
   localparam byte_type FLIP_MASK = 8'h40;
   localparam byte_type CR_BYTE   = 8'h0D;
   localparam byte_type LF_BYTE   = 8'h0A;
   localparam byte_type NUL_BYTE  = 8'h00;

   // reflected CRC-32
   localparam crc_type CRC_INIT = 32'hFFFF_FFFF;
   localparam crc_type CRC_POLY = 32'hEDB8_8320;

   // emit steps of one transaction: header, escape prefix, data, trailer
   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_HDR0 = 4'd0;
   localparam step_type STEP_HDR1 = 4'd1;
   localparam step_type STEP_HDR2 = 4'd2;
   localparam step_type STEP_HDR3 = 4'd3;
   localparam step_type STEP_ESC  = 4'd4;
   localparam step_type STEP_DATA = 4'd5;
   localparam step_type STEP_TRL0 = 4'd6;
   localparam step_type STEP_TRL1 = 4'd7;
   localparam step_type STEP_TRL2 = 4'd8;
   localparam step_type STEP_TRL3 = 4'd9;

endpackage

`default_nettype wire

// ===== hdl/ebfe_req_if.sv =====
// ----------------------------------------------------------------------------
// ebfe_req_if: payload byte channel into the frame encoder
// Valid/ready channel carrying one unescaped payload byte and its framing.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebfe_req_if;

   logic                  valid;
   logic                  ready;
   ebfe_pkg::byte_type    payload_byte;
   ebfe_pkg::byte_type    frame_type;
   logic                  first_of_frame;
   logic                  last_of_frame;

   modport source (
      output valid, payload_byte, frame_type, first_of_frame, last_of_frame,
      input  ready
   );

   modport sink (
      input  valid, payload_byte, frame_type, first_of_frame, last_of_frame,
      output ready
   );

endinterface

`default_nettype wire

// ===== hdl/ebfe_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ebfe_rsp_if: line byte channel out of the frame encoder
// Valid/ready channel carrying one encoded line byte and its end markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebfe_rsp_if;

   logic                  valid;
   logic                  ready;
   ebfe_pkg::byte_type    line_byte;
   logic                  end_of_run;
   logic                  end_of_frame;

   modport source (
      output valid, line_byte, end_of_run, end_of_frame,
      input  ready
   );

   modport sink (
      input  valid, line_byte, end_of_run, end_of_frame,
      output ready
   );

endinterface

`default_nettype wire

// ===== hdl/ebfe_crc_update.sv =====
// ----------------------------------------------------------------------------
// ebfe_crc_update: one-byte reflected CRC-32 update
// Folds one data byte into the CRC register value, LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module ebfe_crc_update (
   input  wire ebfe_pkg::crc_type  crc_cur,
   input  wire ebfe_pkg::byte_type data_byte,
   output ebfe_pkg::crc_type       crc_next
);

   ebfe_pkg::crc_type acc;

   // shift eight bits through the polynomial
   always_comb begin
      acc = crc_cur ^ {{(ebfe_pkg::CRC_W-ebfe_pkg::BYTE_W){1'b0}}, data_byte};
      for (int i = 0; i < ebfe_pkg::BYTE_W; i++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ ebfe_pkg::CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

`default_nettype wire

// ===== hdl/escaped_binary_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// escaped_binary_frame_encoder: binary frame encoder with CRC-32 trailer
// Sends header, escaped payload and LSB-first CRC-32 trailer on a byte line.
// ----------------------------------------------------------------------------
//  channel   dir  port      transaction
//  request   in   req_chan  one payload byte, frame type, first/last marks
//  response  out  rsp_chan  one line byte, end of run, end of frame
//
//  One line byte leaves per cycle unless stalled; a request gives 1 to 10
//  bytes (4 header bytes when first, 1 or 2 data bytes, 4 trailer bytes
//  when last). One-byte requests flow every cycle unless stalled. The next
//  request is taken in the cycle the last byte of the current one enters
//  the output register. Reset clears the stage and output valids and sets
//  the running CRC to all ones. A stalled response holds the output
//  register and backs up into the request stage.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_binary_frame_encoder (
   input  wire         clock,
   input  wire         reset,
   ebfe_req_if.sink    req_chan,
   ebfe_rsp_if.source  rsp_chan
);

   // request stage
   logic                 stage_vld_ff, stage_vld_in;
   ebfe_pkg::byte_type   data_ff, type_ff;
   logic                 first_ff, last_ff, esc_ff;
   ebfe_pkg::crc_type    fin_ff;
   ebfe_pkg::step_type   step_ff, step_in;

   // running CRC
   ebfe_pkg::crc_type    crc_ff, crc_in, crc_base, crc_upd;

   // output register
   logic                 rsp_vld_ff, rsp_vld_in;
   ebfe_pkg::byte_type   line_ff, line_in;
   logic                 eor_ff, eor_in, eof_ff, eof_in;

   logic                 accept, emit, step_last, req_esc;
   ebfe_pkg::step_type   step_start, step_next;
   ebfe_pkg::byte_type   step_byte;

   // handshake
   assign emit      = stage_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign step_last = ((step_ff == ebfe_pkg::STEP_DATA) && !last_ff) ||
                      (step_ff == ebfe_pkg::STEP_TRL3);
   assign req_chan.ready = !stage_vld_ff || (emit && step_last);
   assign accept    = req_chan.valid && req_chan.ready;

   // classify the incoming byte
   assign req_esc = (req_chan.payload_byte == ebfe_pkg::ESC_BYTE) ||
                    (req_chan.payload_byte == ebfe_pkg::CR_BYTE)  ||
                    (req_chan.payload_byte == ebfe_pkg::LF_BYTE)  ||
                    (req_chan.payload_byte == ebfe_pkg::NUL_BYTE);

   assign step_start = req_chan.first_of_frame ? ebfe_pkg::STEP_HDR0 :
                       (req_esc ? ebfe_pkg::STEP_ESC : ebfe_pkg::STEP_DATA);

   // fold the byte into the CRC, restarting on a new frame
   assign crc_base = req_chan.first_of_frame ? ebfe_pkg::CRC_INIT : crc_ff;

   ebfe_crc_update u_crc (
      .crc_cur   (crc_base),
      .data_byte (req_chan.payload_byte),
      .crc_next  (crc_upd)
   );

   always_comb begin
      crc_in = crc_ff;
      if (accept) begin
         crc_in = req_chan.last_of_frame ? ebfe_pkg::CRC_INIT : crc_upd;
      end
   end

   // advance through the emit steps
   always_comb begin
      unique case (step_ff)
         ebfe_pkg::STEP_HDR0: step_next = ebfe_pkg::STEP_HDR1;
         ebfe_pkg::STEP_HDR1: step_next = ebfe_pkg::STEP_HDR2;
         ebfe_pkg::STEP_HDR2: step_next = ebfe_pkg::STEP_HDR3;
         ebfe_pkg::STEP_HDR3: step_next = esc_ff ? ebfe_pkg::STEP_ESC : ebfe_pkg::STEP_DATA;
         ebfe_pkg::STEP_ESC:  step_next = ebfe_pkg::STEP_DATA;
         ebfe_pkg::STEP_DATA: step_next = ebfe_pkg::STEP_TRL0;
         ebfe_pkg::STEP_TRL0: step_next = ebfe_pkg::STEP_TRL1;
         ebfe_pkg::STEP_TRL1: step_next = ebfe_pkg::STEP_TRL2;
         ebfe_pkg::STEP_TRL2: step_next = ebfe_pkg::STEP_TRL3;
         default:             step_next = step_ff;
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      stage_vld_in = stage_vld_ff;
      if (accept) begin
         step_in      = step_start;
         stage_vld_in = 1'b1;
      end else if (emit) begin
         step_in = step_next;
         if (step_last) begin
            stage_vld_in = 1'b0;
         end
      end
   end

   // select the line byte of the current step
   always_comb begin
      unique case (step_ff)
         ebfe_pkg::STEP_HDR0: step_byte = ebfe_pkg::PAD_BYTE;
         ebfe_pkg::STEP_HDR1: step_byte = ebfe_pkg::ESC_BYTE;
         ebfe_pkg::STEP_HDR2: step_byte = ebfe_pkg::BIN_BYTE;
         ebfe_pkg::STEP_HDR3: step_byte = type_ff;
         ebfe_pkg::STEP_ESC:  step_byte = ebfe_pkg::ESC_BYTE;
         ebfe_pkg::STEP_DATA: step_byte = esc_ff ? (data_ff ^ ebfe_pkg::FLIP_MASK) : data_ff;
         ebfe_pkg::STEP_TRL0: step_byte = fin_ff[7:0];
         ebfe_pkg::STEP_TRL1: step_byte = fin_ff[15:8];
         ebfe_pkg::STEP_TRL2: step_byte = fin_ff[23:16];
         ebfe_pkg::STEP_TRL3: step_byte = fin_ff[31:24];
         default:             step_byte = data_ff;
      endcase
   end

   // load or drain the output register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      line_in    = line_ff;
      eor_in     = eor_ff;
      eof_in     = eof_ff;
      if (emit) begin
         rsp_vld_in = 1'b1;
         line_in    = step_byte;
         eor_in     = step_last;
         eof_in     = (step_ff == ebfe_pkg::STEP_TRL3);
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         step_ff      <= ebfe_pkg::STEP_HDR0;
         rsp_vld_ff   <= 1'b0;
         crc_ff       <= ebfe_pkg::CRC_INIT;
      end else begin
         stage_vld_ff <= stage_vld_in;
         step_ff      <= step_in;
         rsp_vld_ff   <= rsp_vld_in;
         crc_ff       <= crc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff  <= req_chan.payload_byte;
         type_ff  <= req_chan.frame_type;
         first_ff <= req_chan.first_of_frame;
         last_ff  <= req_chan.last_of_frame;
         esc_ff   <= req_esc;
         fin_ff   <= crc_upd ^ ebfe_pkg::CRC_INIT;
      end
      line_ff <= line_in;
      eor_ff  <= eor_in;
      eof_ff  <= eof_in;
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.line_byte    = line_ff;
   assign rsp_chan.end_of_run   = eor_ff;
   assign rsp_chan.end_of_frame = eof_ff;

   // the frame end byte always closes its run
   a_eof_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && eof_ff |-> eor_ff)
      else $error("end of frame without end of run");

   // a busy stage takes a new transaction only on its final byte
   a_accept_on_final: assert property (@(posedge clock) disable iff (reset)
      accept && stage_vld_ff |-> emit && step_last)
      else $error("request taken while stage still emitting");

   // the CRC restarts after a frame closes
   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.last_of_frame |=> crc_ff == ebfe_pkg::CRC_INIT)
      else $error("CRC not restarted after frame end");

   // header steps occur only for a first byte
   a_hdr_needs_first: assert property (@(posedge clock) disable iff (reset)
      stage_vld_ff && (step_ff == ebfe_pkg::STEP_HDR0 || step_ff == ebfe_pkg::STEP_HDR1 ||
                       step_ff == ebfe_pkg::STEP_HDR2 || step_ff == ebfe_pkg::STEP_HDR3)
      |-> first_ff)
      else $error("header emitted for a byte that is not first");

   // trailer steps occur only for a last byte
   a_trl_needs_last: assert property (@(posedge clock) disable iff (reset)
      stage_vld_ff && (step_ff == ebfe_pkg::STEP_TRL0 || step_ff == ebfe_pkg::STEP_TRL1 ||
                       step_ff == ebfe_pkg::STEP_TRL2 || step_ff == ebfe_pkg::STEP_TRL3)
      |-> last_ff)
      else $error("trailer emitted for a byte that is not last");

endmodule

`default_nettype wire
